// ===== hdl/oaht_pkg.sv =====
// Shared constants, codes and types for the open-addressing hash table.
package oaht_pkg;

  // Table geometry and probe sequence.
  localparam int TABLE_BITS   = 10;
  localparam int SLOT_COUNT   = 1 << TABLE_BITS;
  localparam int MAX_PROBES   = 10;
  localparam int PROBE_STRIDE = 33;
  localparam int PCW          = $clog2(MAX_PROBES + 1);

  // Field widths.
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [VAL_W-1:0] MISS_CHAR = 8'h20;

  // Request kinds.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef logic [TABLE_BITS-1:0] slot_addr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_WRITE,
    ST_RESULT
  } state_t;

  // Control from the sequencer to the probe address unit.
  typedef struct packed {
    logic start;
    logic step;
  } probe_ctl_t;

  // Write request to the slot stores.
  typedef struct packed {
    logic             key_we;
    logic             val_we;
    slot_addr_t       addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } mem_wr_t;

endpackage

// ===== hdl/oaht_probe_gen.sv =====
// Probe address unit: steps through home + j*j + 33*j by running differences.
module oaht_probe_gen (
  input  logic                clk,
  input  oaht_pkg::probe_ctl_t ctl,
  input  oaht_pkg::slot_addr_t home,
  output oaht_pkg::slot_addr_t addr
);
  import oaht_pkg::*;

  // Difference between probe one and home; later differences grow by two.
  localparam slot_addr_t DELTA_FIRST = slot_addr_t'(PROBE_STRIDE + 1);

  slot_addr_t delta;

  // The offset of probe j+1 exceeds that of probe j by 2j + 34.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      addr  <= home;
      delta <= DELTA_FIRST;
    end else if (ctl.step) begin
      addr  <= addr + delta;
      delta <= delta + slot_addr_t'(2);
    end
  end

endmodule

// ===== hdl/oaht_slot_mem.sv =====
// Key and value stores of the hash table, one write and one registered read port each.
module oaht_slot_mem (
  input  logic                         clk,
  input  oaht_pkg::slot_addr_t         rd_addr,
  input  oaht_pkg::mem_wr_t            wr,
  output logic [oaht_pkg::KEY_W-1:0]   rd_key,
  output logic [oaht_pkg::VAL_W-1:0]   rd_value
);
  import oaht_pkg::*;

  logic [KEY_W-1:0] key_ram [SLOT_COUNT];
  logic [VAL_W-1:0] val_ram [SLOT_COUNT];

  // Key store.
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_ram[wr.addr] <= wr.key;
    end
    rd_key <= key_ram[rd_addr];
  end

  // Value store, read alongside the key.
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_ram[wr.addr] <= wr.value;
    end
    rd_value <= val_ram[rd_addr];
  end

endmodule

// ===== hdl/open_addressing_hash_table_top.sv =====
// Top level of the open-addressing hash table: sequencer, scan state and result register.
//
//   Channel  | Direction | Signals                  | Contents
//   ---------+-----------+--------------------------+---------------------------------------
//   s_       | in        | tvalid tready tdata tuser| request: key, value, cmd
//   m_       | out       | tvalid tready tdata      | result: found, read_value, status
//
// After reset the key store clears all 1024 slots, one slot a cycle, with s_tready low.
// A request with a nonzero key goes through the probe, write and result states before
// the next acceptance: one probe read is issued per cycle through the single memory
// read port, and the probe address unit adds one running difference per cycle.
// A request with key zero skips the scan and goes straight to the result state.
// A result waits in the output register; if it has not been taken when the next result is
// ready, the sequencer holds in its result state until it is.
module open_addressing_hash_table_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [oaht_pkg::IN_DATA_W-1:0]      s_tdata,   // key [31:0], value [39:32]
  input  logic                                s_tuser,   // cmd [0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [oaht_pkg::OUT_DATA_W-1:0]     m_tdata    // found [0], read_value [8:1],
                                                         // status [10:9], zero [15:11]
);
  import oaht_pkg::*;

  state_t           state, state_next;
  probe_ctl_t       probe_ctl;
  mem_wr_t          mem_wr;
  slot_addr_t       probe_addr;
  slot_addr_t       clr_addr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;

  // Request held for the duration of the transaction.
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  // Scan state.
  logic [PCW-1:0]   issue_cnt;
  logic             issuing;
  logic             chk_valid;
  slot_addr_t       chk_addr;
  logic             match_hit;
  logic [VAL_W-1:0] match_val;
  logic             free_hit;
  slot_addr_t       free_addr;

  logic             accept;
  logic             out_load;
  logic [VAL_W-1:0] res_value;
  status_t          res_status;

  oaht_probe_gen u_probe_gen (
    .clk  (clk),
    .ctl  (probe_ctl),
    .home (s_tdata[TABLE_BITS-1:0]),
    .addr (probe_addr)
  );

  oaht_slot_mem u_slot_mem (
    .clk      (clk),
    .rd_addr  (probe_addr),
    .wr       (mem_wr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  assign issuing = (issue_cnt < PCW'(MAX_PROBES));
  assign accept  = s_tvalid && s_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    probe_ctl       = '0;
    out_load        = 1'b0;
    mem_wr.key_we   = 1'b0;
    mem_wr.val_we   = 1'b0;
    mem_wr.addr     = clr_addr;
    mem_wr.key      = '0;
    mem_wr.value    = value_r;
    case (state)
      ST_CLEAR: begin
        mem_wr.key_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          probe_ctl.start = 1'b1;
          state_next = (s_tdata[KEY_W-1:0] == '0) ? ST_RESULT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        probe_ctl.step = issuing;
        if (!issuing && !chk_valid) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (cmd_r == CMD_INSERT && !match_hit && free_hit) begin
          mem_wr.key_we = 1'b1;
          mem_wr.val_we = 1'b1;
          mem_wr.addr   = free_addr;
          mem_wr.key    = key_r;
        end
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: clear sweep, probe count and scan flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      issue_cnt <= '0;
      chk_valid <= 1'b0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + slot_addr_t'(1);
      end
      if (accept) begin
        issue_cnt <= '0;
        chk_valid <= 1'b0;
        match_hit <= 1'b0;
        free_hit  <= 1'b0;
      end else if (state == ST_PROBE) begin
        if (issuing) begin
          issue_cnt <= issue_cnt + PCW'(1);
        end
        chk_valid <= issuing;
        if (chk_valid && rd_key == key_r) begin
          match_hit <= 1'b1;
        end
        if (chk_valid && rd_key == '0) begin
          free_hit <= 1'b1;
        end
      end
    end
  end

  // Request payload and the slots found by the scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= s_tdata[KEY_W-1:0];
      value_r <= s_tdata[KEY_W+VAL_W-1:KEY_W];
      cmd_r   <= s_tuser;
    end
    if (state == ST_PROBE) begin
      chk_addr <= probe_addr;
      if (chk_valid && rd_key == key_r && !match_hit) begin
        match_val <= rd_value;
      end
      if (chk_valid && rd_key == '0 && !free_hit) begin
        free_addr <= chk_addr;
      end
    end
  end

  // Result fields.
  always_comb begin
    res_value = (cmd_r == CMD_LOOKUP && match_hit) ? match_val : MISS_CHAR;
    if (cmd_r == CMD_LOOKUP) begin
      res_status = STATUS_OK;
    end else if (match_hit) begin
      res_status = STATUS_PRESENT;
    end else if (free_hit) begin
      res_status = STATUS_OK;
    end else begin
      res_status = STATUS_DROPPED;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, res_status, res_value, match_hit};
    end
  end

  // A key is only ever written during the clear sweep or into a free slot of a missed insert.
  a_key_write_legal: assert property (@(posedge clk) disable iff (rst)
    mem_wr.key_we |-> (state == ST_CLEAR) ||
                      (state == ST_WRITE && free_hit && !match_hit && cmd_r == CMD_INSERT))
    else $error("key store written outside the clear sweep or a legal insert");

  // An accepted request always starts a scan, or goes straight to the result for key zero.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_PROBE) || (state == ST_RESULT && key_r == '0))
    else $error("accepted request did not start a scan");

  // The probe count never runs past the number of probes.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= PCW'(MAX_PROBES))
    else $error("probe count out of range");

  // A result is loaded only when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while held");

endmodule

// ===== dv/oaht_result_checker.sv =====
// Checker for the hash table: predicts each request's result and compares it with the output.
`timescale 1ns / 100ps

module oaht_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [oaht_pkg::IN_DATA_W-1:0]  s_tdata,   // key [31:0], value [39:32]
  input  logic                            s_tuser,   // cmd [0]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [oaht_pkg::OUT_DATA_W-1:0] m_tdata,   // found [0], read_value [8:1],
                                                     // status [10:9]
  output int                              mismatch_count,
  output int                              outstanding,
  output int                              stored_count,
  output int                              present_count,
  output int                              dropped_count,
  output int                              hit_count,
  output int                              miss_count
);
  import oaht_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] read_value;
    logic             found;
  } lookup_result_t;

  // Shadow copy of the slot stores.
  logic [KEY_W-1:0] shadow_keys [SLOT_COUNT];
  logic [VAL_W-1:0] shadow_values [SLOT_COUNT];

  lookup_result_t expected_results [$];

  // Works out the result of one request and applies its effect to the shadow table.
  function automatic lookup_result_t predict_request(input logic cmd,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] value);
    lookup_result_t r;
    slot_addr_t     slot;
    slot_addr_t     hit_slot;
    slot_addr_t     free_slot;
    logic           hit;
    logic           have_free;
    r.found      = 1'b0;
    r.read_value = MISS_CHAR;
    r.status     = STATUS_OK;
    hit          = 1'b0;
    have_free    = 1'b0;
    hit_slot     = '0;
    free_slot    = '0;
    if (key == '0) begin
      // The empty mark is never stored and never found.
      if (cmd == CMD_INSERT) begin
        r.status = STATUS_DROPPED;
        dropped_count++;
      end else begin
        miss_count++;
      end
      return r;
    end
    // Scan every probe slot, measured from home, for the key and for the first empty slot.
    for (int j = 0; j < MAX_PROBES; j++) begin
      slot = slot_addr_t'(int'(key[TABLE_BITS-1:0]) + j * j + PROBE_STRIDE * j);
      if (!hit && shadow_keys[slot] == key) begin
        hit      = 1'b1;
        hit_slot = slot;
      end
      if (!have_free && shadow_keys[slot] == '0) begin
        have_free = 1'b1;
        free_slot = slot;
      end
    end
    if (cmd == CMD_LOOKUP) begin
      if (hit) begin
        r.found      = 1'b1;
        r.read_value = shadow_values[hit_slot];
        hit_count++;
      end else begin
        miss_count++;
      end
    end else if (hit) begin
      r.found  = 1'b1;
      r.status = STATUS_PRESENT;
      present_count++;
    end else if (have_free) begin
      shadow_keys[free_slot]   = key;
      shadow_values[free_slot] = value;
      stored_count++;
    end else begin
      r.status = STATUS_DROPPED;
      dropped_count++;
    end
    return r;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic report_mismatch(input string what, input lookup_result_t want,
                                 input lookup_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected found %0d value 0x%02h status %0d,",
               $realtime, what, want.found, want.read_value, want.status);
      $display("  got found %0d value 0x%02h status %0d",
               got.found, got.read_value, got.status);
    end
  endtask

  // Results are compared before the request accepted at the same edge is predicted.
  always @(posedge clk) begin : track
    lookup_result_t want;
    lookup_result_t got;
    int             delta;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        shadow_keys[i]   = '0;
        shadow_values[i] = '0;
      end
      expected_results.delete();
      outstanding    <= 0;
      mismatch_count = 0;
      stored_count   = 0;
      present_count  = 0;
      dropped_count  = 0;
      hit_count      = 0;
      miss_count     = 0;
    end else begin
      delta = 0;
      if (m_tvalid && m_tready) begin
        got.found      = m_tdata[0];
        got.read_value = m_tdata[8:1];
        got.status     = status_t'(m_tdata[10:9]);
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          delta--;
          if (got.found != want.found || got.read_value != want.read_value ||
              got.status != want.status) begin
            report_mismatch("result mismatch", want, got);
          end else if (m_tdata[OUT_DATA_W-1:11] != '0) begin
            report_mismatch("nonzero padding in result", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_request(s_tuser, s_tdata[KEY_W-1:0],
                                                   s_tdata[KEY_W+VAL_W-1:KEY_W]));
        delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// ===== dv/open_addressing_hash_table_top_test.sv =====
// Testbench top for the hash table: clock, reset, request stimulus, result acceptor and verdict.
`timescale 1ns / 100ps

module open_addressing_hash_table_top_test;
  import oaht_pkg::*;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 313;
  localparam int SETTLE_CYCLES   = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatch_count;
  int outstanding;
  int stored_count;
  int present_count;
  int dropped_count;
  int hit_count;
  int miss_count;

  int               accepted_count = 0;
  int               burst_left = 0;
  logic             long_hold_done = 1'b0;
  logic [KEY_W-1:0] inserted_keys [$];

  open_addressing_hash_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  oaht_result_checker result_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .stored_count   (stored_count),
    .present_count  (present_count),
    .dropped_count  (dropped_count),
    .hit_count      (hit_count),
    .miss_count     (miss_count)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard limit on the run time, well above the slowest legal run.
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offers one request and returns at the edge where its transaction completes.
  // This task lowers valid only when a burst ends and a gap follows.
  task automatic offer_request(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {value, key};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accepted_count++;
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result acceptor: stretches of differing ready density, rare long hold-offs, and one
  // guaranteed long hold-off while requests keep coming so that the block backs up.
  initial begin : result_acceptor
    int mode;
    int stretch;
    wait (!rst);
    forever begin
      if ((!long_hold_done && accepted_count >= 400) || $urandom_range(0, 199) == 0) begin
        long_hold_done = 1'b1;
        stretch = $urandom_range(300, 500);
        repeat (stretch) begin
          @(posedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          @(posedge clk);
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 9) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Request stimulus and verdict.
  initial begin : request_source
    logic [21:0]        upper_base;
    logic [TABLE_BITS-1:0] homes [4];
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    int                 roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the empty-mark key, the all-ones key whose probes wrap past the top of
    // the table, duplicates, value extremes, and a home whose ten probes fill up.
    offer_request(CMD_LOOKUP, '0, 8'hFF);
    offer_request(CMD_INSERT, '0, 8'h41);
    offer_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    offer_request(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
    offer_request(CMD_INSERT, 32'hFFFF_FFFF, 8'h00);
    offer_request(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    offer_request(CMD_INSERT, 32'd1, 8'h00);
    offer_request(CMD_LOOKUP, 32'd1, 8'hAA);
    for (int k = 0; k <= MAX_PROBES; k++) begin
      offer_request(CMD_INSERT, 32'(5 + k * SLOT_COUNT), 8'(k + 8'h30));
    end
    offer_request(CMD_LOOKUP, 32'(5 + (MAX_PROBES - 1) * SLOT_COUNT), 8'h00);
    offer_request(CMD_LOOKUP, 32'(5 + MAX_PROBES * SLOT_COUNT), 8'h00);
    offer_request(CMD_LOOKUP, 32'd5, 8'h00);
    wait_for_results();

    // Random part: most keys share a few homes per phase so that probe chains fill and
    // overflow; lookups mostly target keys inserted before. The rest is noise.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      upper_base = 22'($urandom);
      foreach (homes[h]) homes[h] = TABLE_BITS'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll  = $urandom_range(0, 99);
        value = VAL_W'($urandom);
        cmd   = 1'($urandom_range(0, 1));
        if (roll < 2) begin
          key = '0;
        end else if (roll < 12) begin
          key = $urandom;
        end else if (cmd == CMD_LOOKUP && inserted_keys.size() > 0 &&
                     $urandom_range(0, 9) < 7) begin
          key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end else begin
          key = {upper_base ^ 22'($urandom_range(0, 15)), homes[$urandom_range(0, 3)]};
        end
        if (cmd == CMD_INSERT && key != '0) inserted_keys.push_back(key);
        offer_request(cmd, key, value);
      end
      wait_for_results();
    end

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d stored, %0d already present, %0d dropped,",
             accepted_count, stored_count, present_count, dropped_count);
    $display("  %0d lookup hits and %0d lookup misses, %0d mismatches.",
             hit_count, miss_count, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/oaht_pkg.sv
hdl/oaht_probe_gen.sv
hdl/oaht_slot_mem.sv
hdl/open_addressing_hash_table_top.sv
dv/oaht_result_checker.sv
dv/open_addressing_hash_table_top_test.sv
